### sv/hta_pkg.sv
// Shared constants, types and a helper function for the handle table allocator.
// No dependencies; every other file refers to this package by scoped names.
package hta_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned HANDLE_STRIDE = 8;

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned HOUT_W = 10;

  // Derived widths
  localparam int unsigned IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned MAX_HANDLE = TABLE_ENTRIES * HANDLE_STRIDE;
  localparam int unsigned HCHK_W     = $clog2(MAX_HANDLE + 1);
  localparam int unsigned Q_W        = $clog2(TABLE_ENTRIES + 1);

  // Division by the stride as a multiply by a rounded-up reciprocal.
  // The extra five fraction bits keep the quotient exact for strides up to 16.
  localparam int unsigned RECIP_SH = HCHK_W + 5;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + HANDLE_STRIDE - 1) / HANDLE_STRIDE;
  localparam int unsigned PROD_W   = HCHK_W + RECIP_W;

  // Width for checking quotient * stride against the handle
  localparam int unsigned CMP_W = (Q_W + 5 > HCHK_W) ? Q_W + 5 : HCHK_W;
  // Width for building an allocated handle
  localparam int unsigned HW_W  = (IDX_W + 6 > HOUT_W) ? IDX_W + 6 : HOUT_W;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] obj;
    logic [DATA_W-1:0] acc;
  } entry_t;

  // Update to the in-use map
  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
  } map_upd_t;

  // Free-entry search result
  typedef struct packed {
    logic any_free;
    idx_t first;
  } map_stat_t;

  // Handle for an entry: (index + 1) * stride, cut to the output field
  function automatic logic [HOUT_W-1:0] handle_of(input idx_t idx);
    logic [HW_W-1:0] hw;
    hw = (HW_W'(idx) + HW_W'(1)) * HW_W'(HANDLE_STRIDE);
    return hw[HOUT_W-1:0];
  endfunction

endpackage

### sv/hta_req_if.sv
// Request channel: valid/ready handshake carrying one table operation.
// Depends on hta_pkg for field widths.
interface hta_req_if;
  logic                          valid;
  logic                          ready;
  logic [hta_pkg::MODE_W-1:0]    mode;
  logic [hta_pkg::DATA_W-1:0]    handle_in;
  logic [hta_pkg::DATA_W-1:0]    object_ref;
  logic [hta_pkg::DATA_W-1:0]    grant_mask;

  modport source (output valid, mode, handle_in, object_ref, grant_mask, input ready);
  modport sink   (input valid, mode, handle_in, object_ref, grant_mask, output ready);
endinterface

### sv/hta_rsp_if.sv
// Response channel: valid/ready handshake carrying one operation result.
// Depends on hta_pkg for field widths.
interface hta_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hta_pkg::STAT_W-1:0]    status;
  logic [hta_pkg::HOUT_W-1:0]    handle_out;
  logic [hta_pkg::DATA_W-1:0]    object_out;
  logic [hta_pkg::DATA_W-1:0]    access_out;

  modport source (output valid, status, handle_out, object_out, access_out, input ready);
  modport sink   (input valid, status, handle_out, object_out, access_out, output ready);
endinterface

### sv/hta_store.sv
// Entry storage: one synchronous RAM of object/access pairs, one write and
// one registered read port. Depends on hta_pkg.
module hta_store (
  input  logic            clk,
  input  logic            wr_en,
  input  hta_pkg::idx_t   wr_idx,
  input  hta_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  hta_pkg::idx_t   rd_idx,
  output hta_pkg::entry_t rd_data
);

  hta_pkg::entry_t mem [hta_pkg::TABLE_ENTRIES];
  hta_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/hta_map.sv
// In-use map: one flop per entry, cleared at reset, with a priority search
// for the lowest free entry. Depends on hta_pkg.
module hta_map (
  input  logic               clk,
  input  logic               rst_n,
  input  hta_pkg::map_upd_t  upd,
  input  hta_pkg::idx_t      chk_idx,
  output logic               chk_used,
  output hta_pkg::map_stat_t stat
);

  logic [hta_pkg::TABLE_ENTRIES-1:0] used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (upd.set) begin
      used_r[upd.idx] <= 1'b1;
    end else if (upd.clr) begin
      used_r[upd.idx] <= 1'b0;
    end
  end

  assign chk_used = used_r[chk_idx];

  // lowest free entry wins
  always_comb begin
    stat = '0;
    for (int i = hta_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        stat.any_free = 1'b1;
        stat.first    = hta_pkg::IDX_W'(i);
      end
    end
  end

endmodule

### sv/handle_table_allocator.sv
// Handle table allocator top level: decode, execute, entry read and result register.
// A request is taken only in idle, once the last one has passed decode, execute and (for a
// look up) the entry RAM read; a waiting result stalls execute and read.
// Reset (rst_n, synchronous, active low) clears the in-use map, so every entry is free
// at once; the entry RAM itself needs no clearing pass.
module handle_table_allocator (
  input  logic              clk,
  input  logic              rst_n,
  hta_req_if.sink           in_ch,
  hta_rsp_if.source         out_ch
);

  // One-hot sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Request held for execute
  logic [hta_pkg::MODE_W-1:0] mode_r;
  logic [hta_pkg::DATA_W-1:0] obj_r;
  logic [hta_pkg::DATA_W-1:0] acc_r;
  logic [hta_pkg::HCHK_W-1:0] hchk_r;
  logic                       inrange_r;
  logic [hta_pkg::Q_W-1:0]    q_r;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic [hta_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [hta_pkg::HOUT_W-1:0] hout_r, hout_nxt;
  logic [hta_pkg::DATA_W-1:0] oout_r, oout_nxt;
  logic [hta_pkg::DATA_W-1:0] aout_r, aout_nxt;
  logic                       load;

  // Decode-side signals
  logic                       in_fire;
  logic [hta_pkg::PROD_W-1:0] prod;
  logic [hta_pkg::HCHK_W-1:0] hchk;
  logic                       inrange;

  // Execute-side signals
  logic                       out_free;
  logic                       exec_go;
  logic                       read_go;
  logic [hta_pkg::CMP_W-1:0]  qs;
  logic                       well_formed;
  hta_pkg::idx_t              slot;
  logic                       slot_used;
  hta_pkg::map_upd_t          map_upd;
  hta_pkg::map_stat_t         map_stat;
  logic                       wr_en;
  logic                       rd_en;
  hta_pkg::entry_t            wr_data;
  hta_pkg::entry_t            rd_data;

  // Take a request only between operations
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Range check and quotient by reciprocal multiply; the remainder check
  // follows in execute
  assign hchk    = in_ch.handle_in[hta_pkg::HCHK_W-1:0];
  assign inrange = (in_ch.handle_in != '0) &&
                   (in_ch.handle_in <= hta_pkg::DATA_W'(hta_pkg::MAX_HANDLE));
  assign prod    = hta_pkg::PROD_W'(hchk) * hta_pkg::PROD_W'(hta_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= in_ch.mode;
      obj_r     <= in_ch.object_ref;
      acc_r     <= in_ch.grant_mask;
      hchk_r    <= hchk;
      inrange_r <= inrange;
      q_r       <= prod[hta_pkg::RECIP_SH +: hta_pkg::Q_W];
    end
  end

  // A handle is well formed when it is in range and an exact multiple of the stride
  assign qs          = hta_pkg::CMP_W'(q_r) * hta_pkg::CMP_W'(hta_pkg::HANDLE_STRIDE);
  assign well_formed = inrange_r && (q_r != '0) && (qs == hta_pkg::CMP_W'(hchk_r));
  assign slot        = hta_pkg::IDX_W'(q_r - hta_pkg::Q_W'(1));

  // Hold execute and read while an untaken result occupies the output register
  assign out_free = !out_valid_r || out_ch.ready;
  assign exec_go  = (state_r == S_EXEC) && out_free;
  assign read_go  = (state_r == S_READ) && out_free;

  hta_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (map_upd),
    .chk_idx  (slot),
    .chk_used (slot_used),
    .stat     (map_stat)
  );

  hta_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (map_stat.first),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (slot),
    .rd_data (rd_data)
  );

  assign wr_data = '{obj: obj_r, acc: acc_r};

  // Execute the operation and form the result
  always_comb begin
    state_nxt  = state_r;
    map_upd    = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    status_nxt = hta_pkg::ST_BAD_HANDLE;
    hout_nxt   = '0;
    oout_nxt   = '0;
    aout_nxt   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          load      = 1'b1;
          case (mode_r)
            hta_pkg::MODE_ALLOC: begin
              if (map_stat.any_free) begin
                // an object of zero is stored but leaves the entry free
                wr_en       = 1'b1;
                map_upd.set = (obj_r != '0);
                map_upd.idx = map_stat.first;
                status_nxt  = hta_pkg::ST_OK;
                hout_nxt    = hta_pkg::handle_of(map_stat.first);
              end else begin
                status_nxt  = hta_pkg::ST_FULL;
              end
            end
            hta_pkg::MODE_FREE: begin
              if (well_formed && slot_used) begin
                map_upd.clr = 1'b1;
                map_upd.idx = slot;
                status_nxt  = hta_pkg::ST_OK;
              end
            end
            hta_pkg::MODE_LOOKUP: begin
              if (well_formed && slot_used) begin
                // fetch the entry; the result loads from the read data
                rd_en     = 1'b1;
                load      = 1'b0;
                state_nxt = S_READ;
              end
            end
            default: begin
              status_nxt = hta_pkg::ST_BAD_HANDLE;
            end
          endcase
        end
      end

      S_READ: begin
        if (read_go) begin
          state_nxt  = S_IDLE;
          load       = 1'b1;
          status_nxt = hta_pkg::ST_OK;
          oout_nxt   = rd_data.obj;
          aout_nxt   = rd_data.acc;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: load on execute or read, drop on the output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      hout_r   <= hout_nxt;
      oout_r   <= oout_nxt;
      aout_r   <= aout_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.handle_out = hout_r;
  assign out_ch.object_out = oout_r;
  assign out_ch.access_out = aout_r;

endmodule

### tb/hta_reply_checker.sv
// Scoreboard for the handle table allocator: mirrors the table, predicts one reply
// per request transfer and compares reply transfers in order.
// Depends on hta_pkg and the hta_req_if / hta_rsp_if interfaces.
module hta_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  hta_req_if          req_ch,
  hta_rsp_if          rsp_ch,
  output int unsigned mismatch_count,
  output int unsigned replies_pending
);

  typedef struct packed {
    logic [hta_pkg::STAT_W-1:0] status;
    logic [hta_pkg::HOUT_W-1:0] handle;
    logic [hta_pkg::DATA_W-1:0] obj;
    logic [hta_pkg::DATA_W-1:0] acc;
  } table_reply_t;

  logic [hta_pkg::DATA_W-1:0] shadow_object [hta_pkg::TABLE_ENTRIES];
  logic [hta_pkg::DATA_W-1:0] shadow_access [hta_pkg::TABLE_ENTRIES];
  table_reply_t               awaited_replies [$];

  // Well formed: nonzero, a stride multiple, and naming an entry inside the table.
  function automatic bit slot_of(input logic [hta_pkg::DATA_W-1:0] h,
                                 output int unsigned slot);
    logic [hta_pkg::DATA_W-1:0] q;
    slot = 0;
    if (h == '0 || (h % hta_pkg::HANDLE_STRIDE) != 0) return 1'b0;
    q = h / hta_pkg::HANDLE_STRIDE;
    if (q < 1 || q > hta_pkg::TABLE_ENTRIES) return 1'b0;
    slot = q - 1;
    return 1'b1;
  endfunction

  function automatic table_reply_t apply_request(input logic [hta_pkg::MODE_W-1:0] op,
                                                 input logic [hta_pkg::DATA_W-1:0] h,
                                                 input logic [hta_pkg::DATA_W-1:0] o,
                                                 input logic [hta_pkg::DATA_W-1:0] a);
    table_reply_t               r;
    int unsigned                slot;
    bit                         well_formed;
    bit                         placed;
    logic [hta_pkg::DATA_W-1:0] hw;
    int                         i;
    r           = '0;
    r.status    = hta_pkg::ST_BAD_HANDLE;
    placed      = 1'b0;
    well_formed = slot_of(h, slot);
    case (op)
      hta_pkg::MODE_ALLOC: begin
        r.status = hta_pkg::ST_FULL;
        for (i = 0; i < hta_pkg::TABLE_ENTRIES; i++) begin
          if (!placed && shadow_object[i] == '0) begin
            // an object of zero still takes the handle but leaves the entry free
            shadow_object[i] = o;
            shadow_access[i] = a;
            hw       = hta_pkg::DATA_W'(i + 1) * hta_pkg::DATA_W'(hta_pkg::HANDLE_STRIDE);
            r.status = hta_pkg::ST_OK;
            r.handle = hw[hta_pkg::HOUT_W-1:0];
            placed   = 1'b1;
          end
        end
      end
      hta_pkg::MODE_FREE: begin
        if (well_formed && shadow_object[slot] != '0) begin
          shadow_object[slot] = '0;
          shadow_access[slot] = '0;
          r.status = hta_pkg::ST_OK;
        end
      end
      hta_pkg::MODE_LOOKUP: begin
        if (well_formed && shadow_object[slot] != '0) begin
          r.status = hta_pkg::ST_OK;
          r.obj    = shadow_object[slot];
          r.acc    = shadow_access[slot];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] hta_reply_checker: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    table_reply_t got;
    table_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < hta_pkg::TABLE_ENTRIES; i++) begin
        shadow_object[i] = '0;
        shadow_access[i] = '0;
      end
      awaited_replies.delete();
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_replies.push_back(apply_request(req_ch.mode, req_ch.handle_in,
                                                req_ch.object_ref, req_ch.grant_mask));
      if ($isunknown(rsp_ch.valid)) report_mismatch("reply valid unknown");
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.handle = rsp_ch.handle_out;
        got.obj    = rsp_ch.object_out;
        got.acc    = rsp_ch.access_out;
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply transfer with no request waiting");
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.handle !== want.handle)
            report_mismatch($sformatf("handle_out got %0d want %0d", got.handle, want.handle));
          if (got.obj !== want.obj)
            report_mismatch($sformatf("object_out got %h want %h", got.obj, want.obj));
          if (got.acc !== want.acc)
            report_mismatch($sformatf("access_out got %h want %h", got.acc, want.acc));
        end
      end
    end
    replies_pending <= awaited_replies.size();
  end

endmodule

### tb/handle_table_allocator_test.sv
// Top of the handle table allocator testbench: clock, reset, request stimulus and
// reply back-pressure, with the verdict taken from hta_reply_checker.
// Depends on hta_pkg, hta_req_if, hta_rsp_if, hta_reply_checker and the block itself.
module handle_table_allocator_test;

  // The mode field's fourth code has no operation behind it
  localparam logic [hta_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned replies_pending;

  hta_req_if req_ch ();
  hta_rsp_if rsp_ch ();

  handle_table_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  hta_reply_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (req_ch),
    .rsp_ch          (rsp_ch),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stall the reply channel at random; the rate follows the current phase.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request, after a random run of idle cycles, and hold it until the
  // transfer. Valid stays high straight into the next request when no gap is drawn.
  task automatic submit(input logic [hta_pkg::MODE_W-1:0] op,
                        input logic [hta_pkg::DATA_W-1:0] h,
                        input logic [hta_pkg::DATA_W-1:0] o,
                        input logic [hta_pkg::DATA_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= op;
    req_ch.handle_in  <= h;
    req_ch.object_ref <= o;
    req_ch.grant_mask <= a;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Mostly handles that name a real entry, so frees and look ups hit live
  // entries; the rest are malformed or out of range.
  function automatic logic [hta_pkg::DATA_W-1:0] pick_handle();
    int unsigned k;
    k = $urandom_range(9);
    if (k <= 6)
      return hta_pkg::DATA_W'($urandom_range(1, hta_pkg::TABLE_ENTRIES)
                              * hta_pkg::HANDLE_STRIDE);
    if (k == 7) return $urandom();
    if (k == 8)
      return hta_pkg::DATA_W'($urandom_range(0, hta_pkg::TABLE_ENTRIES) * hta_pkg::HANDLE_STRIDE
                              + $urandom_range(1, hta_pkg::HANDLE_STRIDE - 1));
    case ($urandom_range(2))
      0:       return '0;
      1:       return hta_pkg::DATA_W'((hta_pkg::TABLE_ENTRIES + $urandom_range(1, 4))
                                       * hta_pkg::HANDLE_STRIDE);
      default: return $urandom() & ~hta_pkg::DATA_W'(hta_pkg::HANDLE_STRIDE - 1);
    endcase
  endfunction

  task automatic submit_random(input int unsigned alloc_pct, input int unsigned free_pct);
    int unsigned                r;
    logic [hta_pkg::DATA_W-1:0] o;
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      // hold back a zero object now and then: the entry must stay free
      o = ($urandom_range(15) == 0) ? '0 : $urandom();
      submit(hta_pkg::MODE_ALLOC, $urandom(), o, $urandom());
    end else if (r < alloc_pct + free_pct) begin
      submit(hta_pkg::MODE_FREE, pick_handle(), $urandom(), $urandom());
    end else if (r < 97) begin
      submit(hta_pkg::MODE_LOOKUP, pick_handle(), $urandom(), $urandom());
    end else begin
      submit(MODE_UNUSED, pick_handle(), $urandom(), $urandom());
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = hta_pkg::MODE_ALLOC;
    req_ch.handle_in  = '0;
    req_ch.object_ref = '0;
    req_ch.grant_mask = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table first, then the special cases one by one.
    submit(hta_pkg::MODE_LOOKUP, 32'd8, '0, '0);                   // look up of a free entry
    submit(hta_pkg::MODE_FREE, 32'd8, '0, '0);                     // free of a free entry
    submit(hta_pkg::MODE_ALLOC, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // all ones into entry 0
    submit(hta_pkg::MODE_ALLOC, '0, '0, 32'h1234_5678);            // zero object: stays free
    submit(hta_pkg::MODE_LOOKUP, 32'd16, '0, '0);                  // so this one is refused
    submit(hta_pkg::MODE_ALLOC, '0, 32'd1, '0);                    // same entry again
    submit(hta_pkg::MODE_LOOKUP, 32'd8, '0, '0);
    submit(hta_pkg::MODE_LOOKUP, 32'd16, '0, '0);
    submit(hta_pkg::MODE_LOOKUP, '0, '0, '0);                      // zero handle
    submit(hta_pkg::MODE_LOOKUP, 32'd7, '0, '0);                   // not a stride multiple
    submit(hta_pkg::MODE_LOOKUP, 32'd12, '0, '0);
    // last entry, then one past the end
    submit(hta_pkg::MODE_LOOKUP,
           hta_pkg::DATA_W'(hta_pkg::TABLE_ENTRIES * hta_pkg::HANDLE_STRIDE), '0, '0);
    submit(hta_pkg::MODE_LOOKUP,
           hta_pkg::DATA_W'((hta_pkg::TABLE_ENTRIES + 1) * hta_pkg::HANDLE_STRIDE), '0, '0);
    submit(hta_pkg::MODE_LOOKUP, 32'hFFFF_FFF8, '0, '0);
    submit(hta_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    submit(hta_pkg::MODE_LOOKUP, 32'h8000_0008, '0, '0);           // high bits must not wrap
    submit(hta_pkg::MODE_FREE, 32'h8000_0010, '0, '0);
    submit(hta_pkg::MODE_FREE, 32'd16, '0, '0);
    submit(hta_pkg::MODE_LOOKUP, 32'd16, '0, '0);
    submit(hta_pkg::MODE_FREE, 32'd16, '0, '0);                    // double free
    submit(MODE_UNUSED, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    submit(hta_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    submit(hta_pkg::MODE_FREE, '0, '0, '0);

    // Random part. Each phase fills the table towards full, then drains it, under
    // one of the idling patterns: none, sender idle, receiver stalling, both.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n < PHASE_ITEMS / 2) submit_random(85, 5);
        else                     submit_random(15, 65);
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: let the pending count catch up with the last transfer, wait for the
    // replies, then keep the clock running so that any stray transfer shows.
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("handle_table_allocator_test: PASS");
    end else begin
      $display("handle_table_allocator_test: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("handle_table_allocator_test: FAIL");
    $finish;
  end

endmodule
